FILE: rtl/jse_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// jse_pkg: shared types, character codes and helpers for the json string escaper
// depends on nothing; used by the interfaces, jse_escape_unit and json_string_escaper

package jse_pkg;

    localparam int BYTE_W    = 8;
    localparam int CAP_W     = 16;
    localparam int SEQ_MAX   = 6;
    localparam int LEN_W     = $clog2(SEQ_MAX + 1);
    localparam int DATA_W    = 32;
    localparam int PADDR_W   = 3;

    localparam logic [CAP_W-1:0] CAP_RESET    = 16'd256;
    localparam logic [CAP_W-1:0] MIN_CAPACITY = 16'd7;
    localparam logic [BYTE_W-1:0] CTRL_LIMIT  = 8'h20;
    localparam logic [3:0]       NIBBLE_MASK  = 4'hF;

    // register index taken from paddr[PADDR_W-1:2]
    localparam logic REG_OUT_CAPACITY = 1'b0;

    localparam logic [BYTE_W-1:0] CHAR_NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CHAR_BACKSPACE = 8'h08;
    localparam logic [BYTE_W-1:0] CHAR_TAB       = 8'h09;
    localparam logic [BYTE_W-1:0] CHAR_LF        = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_FF        = 8'h0C;
    localparam logic [BYTE_W-1:0] CHAR_CR        = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_QUOTE     = 8'h22;
    localparam logic [BYTE_W-1:0] CHAR_ZERO      = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_B   = 8'h62;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_N   = 8'h6E;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_R   = 8'h72;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_T   = 8'h74;
    localparam logic [BYTE_W-1:0] CHAR_LOWER_U   = 8'h75;
    localparam logic [BYTE_W-1:0] HEX_ALPHA_BASE = 8'h37;

    typedef logic [SEQ_MAX-1:0][BYTE_W-1:0] seq_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        seq_t             seq;
        logic             is_end;
        logic [CAP_W-1:0] count_next;
    } esc_result_t;

    // uppercase hex digit of a nibble
    function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
        logic [BYTE_W-1:0] wide;
        begin
            wide = {{(BYTE_W-4){1'b0}}, nib};
            if (nib < 4'd10)
            begin
                hex_digit = CHAR_ZERO + wide;
            end
            else
            begin
                hex_digit = HEX_ALPHA_BASE + wide;
            end
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/jse_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// jse_in_if: input request channel, one source byte or an end item
// depends on jse_pkg

interface jse_in_if;
    logic                         valid;
    logic                         ready;
    logic [jse_pkg::BYTE_W-1:0]   in_byte;
    logic                         end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

`default_nettype wire

FILE: rtl/jse_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// jse_out_if: output request channel, one escaped byte per request
// depends on jse_pkg

interface jse_out_if;
    logic                         valid;
    logic                         ready;
    logic [jse_pkg::BYTE_W-1:0]   out_byte;
    logic                         last_of_run;
    logic                         string_end;

    modport source (output valid, output out_byte, output last_of_run, output string_end,
                    input ready);
    modport sink   (input valid, input out_byte, input last_of_run, input string_end,
                    output ready);
endinterface

`default_nettype wire

FILE: rtl/json_string_escaper.sv
`timescale 1ns / 1ps
`default_nettype none
// json_string_escaper: an input request goes through the input register, then the
// escape logic into the output burst register, which gives the first output byte.
// throughput: one input request per cycle while bytes pass through one for one and
// out_ch is ready; an n-byte escape holds the port until the burst register empties.
// reset: out_capacity 256, output count 0, input and burst registers empty.

module json_string_escaper (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [jse_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [jse_pkg::DATA_W-1:0]    pwdata,
    output logic      [jse_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    jse_in_if.sink                             in_ch,
    jse_out_if.source                          out_ch
);

    logic [jse_pkg::CAP_W-1:0]  cap_reg;
    logic [jse_pkg::CAP_W-1:0]  count_reg;
    logic                       in_valid_reg;
    logic [jse_pkg::BYTE_W-1:0] in_byte_reg;
    logic                       in_end_reg;
    jse_pkg::seq_t              seq_reg;
    jse_pkg::seq_t              seq_next;
    logic [jse_pkg::LEN_W-1:0]  left_reg;
    logic [jse_pkg::LEN_W-1:0]  left_next;
    logic                       end_reg;
    logic                       end_next;
    jse_pkg::esc_result_t       esc;
    logic                       cfg_write;
    logic                       in_fire;
    logic                       out_fire;
    logic                       move;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[jse_pkg::PADDR_W-1:2] == jse_pkg::REG_OUT_CAPACITY);
    assign prdata    = (paddr[jse_pkg::PADDR_W-1:2] == jse_pkg::REG_OUT_CAPACITY)
                     ? {{(jse_pkg::DATA_W-jse_pkg::CAP_W){1'b0}}, cap_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= jse_pkg::CAP_RESET;
        end
        else if (cfg_write)
        begin
            cap_reg <= pwdata[jse_pkg::CAP_W-1:0];
        end
    end

    jse_escape_unit u_escape (
        .in_byte       (in_byte_reg),
        .end_of_string (in_end_reg),
        .count         (count_reg),
        .capacity      (cap_reg),
        .result        (esc)
    );

    assign out_fire = out_ch.valid && out_ch.ready;
    assign move     = in_valid_reg
                   && ((left_reg == '0) || ((left_reg == jse_pkg::LEN_W'(1)) && out_ch.ready));
    assign in_ch.ready = !in_valid_reg || move;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (move)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_byte_reg <= in_ch.in_byte;
            in_end_reg  <= in_ch.end_of_string;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (move)
        begin
            count_reg <= esc.count_next;
        end
    end

    always_comb
    begin
        seq_next  = seq_reg;
        left_next = left_reg;
        end_next  = end_reg;
        if (move)
        begin
            seq_next  = esc.seq;
            left_next = esc.len;
            end_next  = esc.is_end;
        end
        else if (out_fire)
        begin
            seq_next  = seq_reg >> jse_pkg::BYTE_W;
            left_next = left_reg - jse_pkg::LEN_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= '0;
            end_reg  <= 1'b0;
        end
        else
        begin
            left_reg <= left_next;
            end_reg  <= end_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
    end

    assign out_ch.valid       = (left_reg != '0);
    assign out_ch.out_byte    = seq_reg[0];
    assign out_ch.last_of_run = (left_reg == jse_pkg::LEN_W'(1));
    assign out_ch.string_end  = end_reg;

    a_nul_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.string_end |-> out_ch.last_of_run)
        else $error("terminating nul not marked as last byte");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !move |=> in_valid_reg)
        else $error("held input request lost");

    a_count_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && out_ch.string_end |-> count_reg == '0)
        else $error("output count not cleared by end request");

endmodule

`default_nettype wire

FILE: rtl/jse_escape_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// jse_escape_unit: maps one source byte or end item to its escape sequence,
// applies the capacity check and gives the next output count; depends on jse_pkg

module jse_escape_unit (
    input  wire logic [jse_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                       end_of_string,
    input  wire logic [jse_pkg::CAP_W-1:0]  count,
    input  wire logic [jse_pkg::CAP_W-1:0]  capacity,
    output jse_pkg::esc_result_t            result
);

    logic [jse_pkg::LEN_W-1:0] raw_len;
    jse_pkg::seq_t             raw_seq;
    logic [jse_pkg::CAP_W-1:0] len_wide;
    logic                      fits;

    always_comb
    begin
        raw_seq    = '0;
        raw_seq[0] = jse_pkg::CHAR_BACKSLASH;
        raw_len    = jse_pkg::LEN_W'(2);
        priority if (in_byte == jse_pkg::CHAR_QUOTE || in_byte == jse_pkg::CHAR_BACKSLASH)
        begin
            raw_seq[1] = in_byte;
        end
        else if (in_byte == jse_pkg::CHAR_LF)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_N;
        end
        else if (in_byte == jse_pkg::CHAR_CR)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_R;
        end
        else if (in_byte == jse_pkg::CHAR_TAB)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_T;
        end
        else if (in_byte == jse_pkg::CHAR_BACKSPACE)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_B;
        end
        else if (in_byte == jse_pkg::CHAR_FF)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_F;
        end
        else if (in_byte < jse_pkg::CTRL_LIMIT)
        begin
            raw_seq[1] = jse_pkg::CHAR_LOWER_U;
            raw_seq[2] = jse_pkg::CHAR_ZERO;
            raw_seq[3] = jse_pkg::CHAR_ZERO;
            raw_seq[4] = jse_pkg::hex_digit(in_byte[7:4] & jse_pkg::NIBBLE_MASK);
            raw_seq[5] = jse_pkg::hex_digit(in_byte[3:0] & jse_pkg::NIBBLE_MASK);
            raw_len    = jse_pkg::LEN_W'(jse_pkg::SEQ_MAX);
        end
        else
        begin
            raw_seq[0] = in_byte;
            raw_len    = jse_pkg::LEN_W'(1);
        end
    end

    assign len_wide = {{(jse_pkg::CAP_W-jse_pkg::LEN_W){1'b0}}, raw_len};

    // capacity >= 7 guards both subtractions against wrap
    assign fits = (capacity >= jse_pkg::MIN_CAPACITY)
               && (count < capacity - jse_pkg::CAP_W'(1))
               && ((raw_len == jse_pkg::LEN_W'(1)) || (count < capacity - len_wide));

    always_comb
    begin
        result = '0;
        if (end_of_string)
        begin
            result.seq[0]     = jse_pkg::CHAR_NUL;
            result.len        = (capacity != '0) ? jse_pkg::LEN_W'(1) : '0;
            result.is_end     = 1'b1;
            result.count_next = '0;
        end
        else if (fits)
        begin
            result.seq        = raw_seq;
            result.len        = raw_len;
            result.count_next = count + len_wide;
        end
        else
        begin
            result.count_next = count;
        end
    end

endmodule

`default_nettype wire
